### hw/rtl/rau_pkg.sv
`default_nettype none

package rau_pkg;

  // Operand and datapath widths.
  localparam int unsigned OPERAND_WIDTH = 16;
  localparam int unsigned PROD_W        = 2 * OPERAND_WIDTH;
  localparam int unsigned MAG_W         = 2 * OPERAND_WIDTH + 1;
  localparam int unsigned RES_W         = 32;
  localparam int unsigned EXT_W         = (MAG_W > RES_W) ? MAG_W : RES_W;
  localparam int unsigned CNT_W         = $clog2(MAG_W + 1);
  localparam int unsigned PC_W          = 4;

  // Operation codes of the operation field.
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // Datapath micro-operations.
  typedef enum logic [3:0] {
    UOP_NOP         = 4'd0,
    UOP_LOAD        = 4'd1,
    UOP_MUL_N       = 4'd2,
    UOP_MUL_D       = 4'd3,
    UOP_MUL_T       = 4'd4,
    UOP_COMBINE     = 4'd5,
    UOP_GCD_INIT    = 4'd6,
    UOP_GCD_STEP    = 4'd7,
    UOP_GCD_DONE    = 4'd8,
    UOP_DIV_N_START = 4'd9,
    UOP_DIV_N_WAIT  = 4'd10,
    UOP_DIV_D_START = 4'd11,
    UOP_DIV_D_WAIT  = 4'd12,
    UOP_OUTPUT      = 4'd13
  } uop_e;

  // Jump conditions of the sequencer.
  typedef enum logic [2:0] {
    COND_NONE        = 3'd0,
    COND_NO_IN       = 3'd1,
    COND_MULDIV      = 3'd2,
    COND_GCD_RUN     = 3'd3,
    COND_GCD_ZERO    = 3'd4,
    COND_DIV_BUSY    = 3'd5,
    COND_OUT_BLOCKED = 3'd6
  } cond_e;

  // One control word of the microprogram.
  typedef struct packed {
    uop_e            uop;
    cond_e           cond;
    logic [PC_W-1:0] target;
    logic            wrap;
  } ctrl_t;

  // Status flags returned by the datapath.
  typedef struct packed {
    logic in_fire;
    logic op_muldiv;
    logic gcd_run;
    logic gcd_zero;
    logic div_busy;
    logic out_blocked;
  } stat_t;

  // Program step addresses.
  localparam logic [PC_W-1:0] STEP_IDLE      = 4'd0;
  localparam logic [PC_W-1:0] STEP_MUL_N     = 4'd1;
  localparam logic [PC_W-1:0] STEP_MUL_D     = 4'd2;
  localparam logic [PC_W-1:0] STEP_MUL_T     = 4'd3;
  localparam logic [PC_W-1:0] STEP_COMBINE   = 4'd4;
  localparam logic [PC_W-1:0] STEP_GCD_INIT  = 4'd5;
  localparam logic [PC_W-1:0] STEP_GCD_STEP  = 4'd6;
  localparam logic [PC_W-1:0] STEP_GCD_DONE  = 4'd7;
  localparam logic [PC_W-1:0] STEP_DIVN_GO   = 4'd8;
  localparam logic [PC_W-1:0] STEP_DIVN_WAIT = 4'd9;
  localparam logic [PC_W-1:0] STEP_DIVD_GO   = 4'd10;
  localparam logic [PC_W-1:0] STEP_DIVD_WAIT = 4'd11;
  localparam logic [PC_W-1:0] STEP_OUTPUT    = 4'd12;

  // Microprogram ROM. A taken jump goes to target; otherwise the next step,
  // or the idle step when wrap is set.
  function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] step);
    ctrl_t w;
    w = '{uop: UOP_NOP, cond: COND_NONE, target: STEP_IDLE, wrap: 1'b0};
    unique case (step)
      STEP_IDLE: begin
        w.uop    = UOP_LOAD;
        w.cond   = COND_NO_IN;
        w.target = STEP_IDLE;
      end
      STEP_MUL_N:   w.uop = UOP_MUL_N;
      STEP_MUL_D:   w.uop = UOP_MUL_D;
      STEP_MUL_T: begin
        w.uop    = UOP_MUL_T;
        w.cond   = COND_MULDIV;
        w.target = STEP_GCD_INIT;
      end
      STEP_COMBINE:  w.uop = UOP_COMBINE;
      STEP_GCD_INIT: w.uop = UOP_GCD_INIT;
      STEP_GCD_STEP: begin
        w.uop    = UOP_GCD_STEP;
        w.cond   = COND_GCD_RUN;
        w.target = STEP_GCD_STEP;
      end
      STEP_GCD_DONE: begin
        w.uop    = UOP_GCD_DONE;
        w.cond   = COND_GCD_ZERO;
        w.target = STEP_OUTPUT;
      end
      STEP_DIVN_GO: w.uop = UOP_DIV_N_START;
      STEP_DIVN_WAIT: begin
        w.uop    = UOP_DIV_N_WAIT;
        w.cond   = COND_DIV_BUSY;
        w.target = STEP_DIVN_WAIT;
      end
      STEP_DIVD_GO: w.uop = UOP_DIV_D_START;
      STEP_DIVD_WAIT: begin
        w.uop    = UOP_DIV_D_WAIT;
        w.cond   = COND_DIV_BUSY;
        w.target = STEP_DIVD_WAIT;
      end
      STEP_OUTPUT: begin
        w.uop    = UOP_OUTPUT;
        w.cond   = COND_OUT_BLOCKED;
        w.target = STEP_OUTPUT;
        w.wrap   = 1'b1;
      end
      default: w.wrap = 1'b1;
    endcase
    return w;
  endfunction

  // Magnitude of a two's complement operand; the most negative value maps
  // to its true magnitude as an unsigned number.
  function automatic logic [OPERAND_WIDTH-1:0] abs_mag(
    input logic [OPERAND_WIDTH-1:0] v
  );
    return v[OPERAND_WIDTH-1] ? OPERAND_WIDTH'(~v + OPERAND_WIDTH'(1)) : v;
  endfunction

  // Sign-magnitude to the low bits of the two's complement result.
  function automatic logic [RES_W-1:0] to_res(input logic neg,
                                              input logic [MAG_W-1:0] mag);
    logic [EXT_W-1:0] e;
    e = EXT_W'(mag);
    if (neg) begin
      e = EXT_W'(~e + EXT_W'(1));
    end
    return e[RES_W-1:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/rau_divider.sv
`default_nettype none

module rau_divider
  import rau_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [MAG_W-1:0] dividend_i,
  input  wire logic [MAG_W-1:0] divisor_i,
  output logic                  busy_o,
  output logic [MAG_W-1:0]      quotient_o
);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [MAG_W-1:0] rem_q, rem_d;
  logic [MAG_W-1:0] quo_q, quo_d;
  logic [MAG_W-1:0] dsr_q, dsr_d;
  logic [MAG_W:0]   shifted;
  logic [MAG_W+1:0] diff;
  logic             fits;

  // One restoring division step: shift in the next dividend bit and try
  // to subtract the divisor.
  assign shifted = {rem_q, quo_q[MAG_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_q};
  assign fits    = ~diff[MAG_W+1];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(MAG_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];
      quo_d = {quo_q[MAG_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

### hw/rtl/rau_datapath.sv
`default_nettype none

module rau_datapath
  import rau_pkg::*;
(
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire ctrl_t                           ctrl_i,
  output stat_t                                stat_o,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [1:0]                      operation_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] a_num_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] a_den_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] b_num_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] b_den_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic signed [RES_W-1:0]              res_num_o,
  output logic signed [RES_W-1:0]              res_den_o,
  output logic                                 zero_gcd_error_o
);

  // Operand registers in sign-magnitude form.
  op_e                      op_q, op_d;
  logic [OPERAND_WIDTH-1:0] an_mag_q, ad_mag_q, bn_mag_q, bd_mag_q;
  logic [OPERAND_WIDTH-1:0] an_mag_d, ad_mag_d, bn_mag_d, bd_mag_d;
  logic                     an_neg_q, ad_neg_q, bn_neg_q, bd_neg_q;
  logic                     an_neg_d, ad_neg_d, bn_neg_d, bd_neg_d;

  // Working registers.
  logic [MAG_W-1:0] num_mag_q, num_mag_d, den_mag_q, den_mag_d, tmp_mag_q, tmp_mag_d;
  logic             num_neg_q, num_neg_d, den_neg_q, den_neg_d, tmp_neg_q, tmp_neg_d;
  logic [MAG_W-1:0] gx_q, gx_d, gy_q, gy_d;
  logic [CNT_W-1:0] gk_q, gk_d;
  logic             err_q, err_d;

  // Result register.
  logic             out_valid_q, out_valid_d;
  logic [RES_W-1:0] res_num_q, res_num_d, res_den_q, res_den_d;
  logic             res_err_q, res_err_d;

  // Shared multiplier and divider.
  logic [OPERAND_WIDTH-1:0] mul_x, mul_y;
  logic                     mul_sx, mul_sy;
  logic [PROD_W-1:0]        prod;
  logic                     prod_neg;
  logic                     div_start, div_busy;
  logic [MAG_W-1:0]         div_dividend, div_quot;

  // Signed add of the two cross products.
  logic             t_neg;
  logic [MAG_W-1:0] sum_mag;
  logic             sum_neg;

  logic in_fire, out_blocked, gcd_run, gcd_zero;

  assign in_stall_o  = (ctrl_i.uop != UOP_LOAD);
  assign in_fire     = in_valid_i && (ctrl_i.uop == UOP_LOAD);
  assign out_blocked = out_valid_q && out_stall_i;
  assign gcd_run     = (gx_q != '0) && (gy_q != '0);
  assign gcd_zero    = ((gx_q | gy_q) == '0);

  assign stat_o = '{
    in_fire:     in_fire,
    op_muldiv:   (op_q == OP_MUL) || (op_q == OP_DIV),
    gcd_run:     gcd_run,
    gcd_zero:    gcd_zero,
    div_busy:    div_busy,
    out_blocked: out_blocked
  };

  // Multiplier operand selection per micro-operation.
  always_comb begin
    mul_x  = bn_mag_q;
    mul_sx = bn_neg_q;
    mul_y  = ad_mag_q;
    mul_sy = ad_neg_q;
    unique case (ctrl_i.uop)
      UOP_MUL_N: begin
        mul_x  = an_mag_q;
        mul_sx = an_neg_q;
        mul_y  = (op_q == OP_MUL) ? bn_mag_q : bd_mag_q;
        mul_sy = (op_q == OP_MUL) ? bn_neg_q : bd_neg_q;
      end
      UOP_MUL_D: begin
        mul_x  = ad_mag_q;
        mul_sx = ad_neg_q;
        mul_y  = (op_q == OP_DIV) ? bn_mag_q : bd_mag_q;
        mul_sy = (op_q == OP_DIV) ? bn_neg_q : bd_neg_q;
      end
      default: begin
      end
    endcase
  end

  assign prod     = PROD_W'(mul_x) * PROD_W'(mul_y);
  assign prod_neg = (prod != '0) && (mul_sx != mul_sy);

  // Add or subtract the second cross product from the first.
  always_comb begin
    t_neg = (op_q == OP_SUB) ? ((tmp_mag_q != '0) && !tmp_neg_q) : tmp_neg_q;
    if (num_neg_q == t_neg) begin
      sum_mag = num_mag_q + tmp_mag_q;
      sum_neg = num_neg_q;
    end else if (num_mag_q >= tmp_mag_q) begin
      sum_mag = num_mag_q - tmp_mag_q;
      sum_neg = num_neg_q;
    end else begin
      sum_mag = tmp_mag_q - num_mag_q;
      sum_neg = t_neg;
    end
    if (sum_mag == '0) begin
      sum_neg = 1'b0;
    end
  end

  // Datapath register updates selected by the control word.
  always_comb begin
    op_d      = op_q;
    an_mag_d  = an_mag_q;
    ad_mag_d  = ad_mag_q;
    bn_mag_d  = bn_mag_q;
    bd_mag_d  = bd_mag_q;
    an_neg_d  = an_neg_q;
    ad_neg_d  = ad_neg_q;
    bn_neg_d  = bn_neg_q;
    bd_neg_d  = bd_neg_q;
    num_mag_d = num_mag_q;
    num_neg_d = num_neg_q;
    den_mag_d = den_mag_q;
    den_neg_d = den_neg_q;
    tmp_mag_d = tmp_mag_q;
    tmp_neg_d = tmp_neg_q;
    gx_d      = gx_q;
    gy_d      = gy_q;
    gk_d      = gk_q;
    err_d     = err_q;
    res_num_d = res_num_q;
    res_den_d = res_den_q;
    res_err_d = res_err_q;
    div_start    = 1'b0;
    div_dividend = num_mag_q;

    // The result register empties on a transfer.
    out_valid_d = out_valid_q && out_stall_i;

    unique case (ctrl_i.uop)
      UOP_LOAD: begin
        if (in_fire) begin
          op_d     = op_e'(operation_i);
          an_mag_d = abs_mag(a_num_i);
          ad_mag_d = abs_mag(a_den_i);
          bn_mag_d = abs_mag(b_num_i);
          bd_mag_d = abs_mag(b_den_i);
          an_neg_d = a_num_i[OPERAND_WIDTH-1];
          ad_neg_d = a_den_i[OPERAND_WIDTH-1];
          bn_neg_d = b_num_i[OPERAND_WIDTH-1];
          bd_neg_d = b_den_i[OPERAND_WIDTH-1];
        end
      end
      UOP_MUL_N: begin
        num_mag_d = MAG_W'(prod);
        num_neg_d = prod_neg;
      end
      UOP_MUL_D: begin
        den_mag_d = MAG_W'(prod);
        den_neg_d = prod_neg;
      end
      UOP_MUL_T: begin
        tmp_mag_d = MAG_W'(prod);
        tmp_neg_d = prod_neg;
      end
      UOP_COMBINE: begin
        num_mag_d = sum_mag;
        num_neg_d = sum_neg;
      end
      UOP_GCD_INIT: begin
        gx_d = num_mag_q;
        gy_d = den_mag_q;
        gk_d = '0;
      end
      UOP_GCD_STEP: begin
        // Binary gcd: strip common factors of two, then odd differences.
        if (gcd_run) begin
          if (!gx_q[0] && !gy_q[0]) begin
            gx_d = gx_q >> 1;
            gy_d = gy_q >> 1;
            gk_d = gk_q + CNT_W'(1);
          end else if (!gx_q[0]) begin
            gx_d = gx_q >> 1;
          end else if (!gy_q[0]) begin
            gy_d = gy_q >> 1;
          end else if (gx_q >= gy_q) begin
            gx_d = gx_q - gy_q;
          end else begin
            gy_d = gy_q - gx_q;
          end
        end
      end
      UOP_GCD_DONE: begin
        gx_d  = MAG_W'((gx_q | gy_q) << gk_q);
        err_d = gcd_zero;
      end
      UOP_DIV_N_START: begin
        div_start    = 1'b1;
        div_dividend = num_mag_q;
      end
      UOP_DIV_N_WAIT: begin
        if (!div_busy) begin
          num_mag_d = div_quot;
        end
      end
      UOP_DIV_D_START: begin
        div_start    = 1'b1;
        div_dividend = den_mag_q;
      end
      UOP_DIV_D_WAIT: begin
        if (!div_busy) begin
          den_mag_d = div_quot;
        end
      end
      UOP_OUTPUT: begin
        if (!out_blocked) begin
          out_valid_d = 1'b1;
          res_num_d   = to_res(num_neg_q, num_mag_q);
          res_den_d   = to_res(den_neg_q, den_mag_q);
          res_err_d   = err_q;
        end
      end
      default: begin
      end
    endcase
  end

  rau_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (gx_q),
    .busy_o     (div_busy),
    .quotient_o (div_quot)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    an_mag_q  <= an_mag_d;
    ad_mag_q  <= ad_mag_d;
    bn_mag_q  <= bn_mag_d;
    bd_mag_q  <= bd_mag_d;
    an_neg_q  <= an_neg_d;
    ad_neg_q  <= ad_neg_d;
    bn_neg_q  <= bn_neg_d;
    bd_neg_q  <= bd_neg_d;
    num_mag_q <= num_mag_d;
    num_neg_q <= num_neg_d;
    den_mag_q <= den_mag_d;
    den_neg_q <= den_neg_d;
    tmp_mag_q <= tmp_mag_d;
    tmp_neg_q <= tmp_neg_d;
    gx_q      <= gx_d;
    gy_q      <= gy_d;
    gk_q      <= gk_d;
    err_q     <= err_d;
    res_num_q <= res_num_d;
    res_den_q <= res_den_d;
    res_err_q <= res_err_d;
  end

  assign out_valid_o      = out_valid_q;
  assign res_num_o        = res_num_q;
  assign res_den_o        = res_den_q;
  assign zero_gcd_error_o = res_err_q;

endmodule

`default_nettype wire

### hw/rtl/rau_sequencer.sv
`default_nettype none

module rau_sequencer
  import rau_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire stat_t stat_i,
  output ctrl_t      ctrl_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_t           word;
  logic            take;

  // Fetch the control word of the current step.
  assign word   = ucode_rom(pc_q);
  assign ctrl_o = word;

  // Evaluate the jump condition.
  always_comb begin
    unique case (word.cond)
      COND_NONE:        take = 1'b0;
      COND_NO_IN:       take = !stat_i.in_fire;
      COND_MULDIV:      take = stat_i.op_muldiv;
      COND_GCD_RUN:     take = stat_i.gcd_run;
      COND_GCD_ZERO:    take = stat_i.gcd_zero;
      COND_DIV_BUSY:    take = stat_i.div_busy;
      COND_OUT_BLOCKED: take = stat_i.out_blocked;
      default:          take = 1'b0;
    endcase
  end

  // Next step: jump target, wrap to idle, or fall through.
  always_comb begin
    if (take) begin
      pc_d = word.target;
    end else if (word.wrap) begin
      pc_d = STEP_IDLE;
    end else begin
      pc_d = pc_q + PC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rational_arithmetic_unit.sv
// Each transfer runs the cross products, a binary gcd loop and two bit-serial divisions;
// when both parts are zero the divisions are skipped and the zero-gcd flag is set.
// Throughput: one item at a time; the next item can be taken in the same cycle that the result becomes valid.
// Reset: asynchronous, active low; clears the step counter, the result valid and the divider's busy flag and count.
`default_nettype none

module rational_arithmetic_unit
  import rau_pkg::*;
(
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [1:0]                      operation_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] a_num_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] a_den_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] b_num_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] b_den_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic signed [RES_W-1:0]              res_num_o,
  output logic signed [RES_W-1:0]              res_den_o,
  output logic                                 zero_gcd_error_o
);

  ctrl_t ctrl;
  stat_t stat;

  // Microprogram sequencer.
  rau_sequencer u_sequencer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // Datapath with shared multiplier, gcd registers and divider.
  rau_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .a_num_i          (a_num_i),
    .a_den_i          (a_den_i),
    .b_num_i          (b_num_i),
    .b_den_i          (b_den_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .res_num_o        (res_num_o),
    .res_den_o        (res_den_o),
    .zero_gcd_error_o (zero_gcd_error_o)
  );

endmodule

`default_nettype wire

### tb/tb.sv
`default_nettype none

module tb;
  import rau_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned SETTLE_TICKS = 250;

  typedef logic signed [OPERAND_WIDTH-1:0] operand_t;

  // One pair of fractions together with the operation to apply.
  typedef struct {
    op_e      op;
    operand_t a_num;
    operand_t a_den;
    operand_t b_num;
    operand_t b_den;
  } fraction_pair_t;

  // One reduced fraction as the block reports it.
  typedef struct {
    logic signed [RES_W-1:0] num;
    logic signed [RES_W-1:0] den;
    logic                    zero_err;
  } reduced_t;

  logic                    clk_i            = 1'b0;
  logic                    rst_ni           = 1'b0;
  logic                    in_valid_i       = 1'b0;
  logic                    in_stall_o;
  logic [1:0]              operation_i      = 2'd0;
  operand_t                a_num_i          = '0;
  operand_t                a_den_i          = '0;
  operand_t                b_num_i          = '0;
  operand_t                b_den_i          = '0;
  logic                    out_valid_o;
  logic                    out_stall_i      = 1'b0;
  logic signed [RES_W-1:0] res_num_o;
  logic signed [RES_W-1:0] res_den_o;
  logic                    zero_gcd_error_o;

  fraction_pair_t pair_queue[$];
  reduced_t       reduced_queue[$];
  fraction_pair_t cur_pair;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;
  int unsigned pairs_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned zero_gcd_seen  = 0;
  int unsigned fail_count     = 0;

  rational_arithmetic_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .a_num_i          (a_num_i),
    .a_den_i          (a_den_i),
    .b_num_i          (b_num_i),
    .b_den_i          (b_den_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .res_num_o        (res_num_o),
    .res_den_o        (res_den_o),
    .zero_gcd_error_o (zero_gcd_error_o)
  );

  // Free-running clock.
  always #1 clk_i = ~clk_i;

  // Exact cross-multiplication, then reduction by the gcd of the magnitudes.
  function automatic reduced_t reduce_pair(input fraction_pair_t p);
    longint          n;
    longint          d;
    longint unsigned x;
    longint unsigned y;
    longint unsigned t;
    reduced_t        r;
    case (p.op)
      OP_ADD: n = longint'(p.a_num) * p.b_den + longint'(p.b_num) * p.a_den;
      OP_SUB: n = longint'(p.a_num) * p.b_den - longint'(p.b_num) * p.a_den;
      OP_MUL: n = longint'(p.a_num) * p.b_num;
      default: n = longint'(p.a_num) * p.b_den;
    endcase
    if (p.op == OP_DIV) begin
      d = longint'(p.a_den) * p.b_num;
    end else begin
      d = longint'(p.a_den) * p.b_den;
    end
    x = (n < 0) ? longint'(-n) : n;
    y = (d < 0) ? longint'(-d) : d;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    if (x == 0) begin
      r.num      = '0;
      r.den      = '0;
      r.zero_err = 1'b1;
    end else begin
      n          = n / longint'(x);
      d          = d / longint'(x);
      r.num      = n[RES_W-1:0];
      r.den      = d[RES_W-1:0];
      r.zero_err = 1'b0;
    end
    return r;
  endfunction

  // Operand mix: full range, small values that share factors, zeros, extremes.
  function automatic operand_t pick_operand();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 45) begin
      return OPERAND_WIDTH'($urandom);
    end else if (sel < 75) begin
      return OPERAND_WIDTH'(int'($urandom_range(40)) - 20);
    end else if (sel < 85) begin
      return '0;
    end
    case ($urandom_range(3))
      0: return {1'b1, {(OPERAND_WIDTH-1){1'b0}}};
      1: return {1'b0, {(OPERAND_WIDTH-1){1'b1}}};
      2: return '1;
      default: return operand_t'(1);
    endcase
  endfunction

  task automatic push_pair(input op_e op, input operand_t an, input operand_t ad,
                           input operand_t bn, input operand_t bd);
    fraction_pair_t p;
    p.op    = op;
    p.a_num = an;
    p.a_den = ad;
    p.b_num = bn;
    p.b_den = bd;
    pair_queue.push_back(p);
  endtask

  // Hold the sender back until every transfer has produced its result.
  task automatic drain();
    while (pair_queue.size() != 0 || in_valid_i || reduced_queue.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Driver: records the expectation on each input transfer, then offers the next pair.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        reduced_queue.push_back(reduce_pair(cur_pair));
        pairs_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pair_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_pair    = pair_queue.pop_front();
          operation_i <= cur_pair.op;
          a_num_i     <= cur_pair.a_num;
          a_den_i     <= cur_pair.a_den;
          b_num_i     <= cur_pair.b_num;
          b_den_i     <= cur_pair.b_den;
          in_valid_i  <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each output transfer with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    reduced_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (zero_gcd_error_o) begin
          zero_gcd_seen++;
        end
        if (reduced_queue.size() == 0) begin
          $error("result %0d/%0d with no pending expectation", res_num_o, res_den_o);
          fail_count++;
        end else begin
          want = reduced_queue.pop_front();
          if (res_num_o !== want.num) begin
            $error("res_num: expected %0d, got %0d", want.num, res_num_o);
            fail_count++;
          end
          if (res_den_o !== want.den) begin
            $error("res_den: expected %0d, got %0d", want.den, res_den_o);
            fail_count++;
          end
          if (zero_gcd_error_o !== want.zero_err) begin
            $error("zero_gcd_error: expected %0b, got %0b", want.zero_err,
                   zero_gcd_error_o);
            fail_count++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus: directed corner cases, then random pairs under four idling patterns.
  initial begin
    operand_t omin;
    operand_t omax;
    omin = {1'b1, {(OPERAND_WIDTH-1){1'b0}}};
    omax = {1'b0, {(OPERAND_WIDTH-1){1'b1}}};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Ordinary sums and a sum that cancels to zero.
    push_pair(OP_ADD, 1, 2, 1, 3);
    push_pair(OP_SUB, 1, 2, 1, 2);
    // Both parts zero raise the flag.
    push_pair(OP_MUL, 0, 0, 5, 7);
    push_pair(OP_ADD, 1, 0, 1, 0);
    push_pair(OP_DIV, 0, 0, 0, 0);
    // Zero denominator only, with either sign of numerator.
    push_pair(OP_DIV, 3, 4, 0, 5);
    push_pair(OP_DIV, -3, 4, 0, 5);
    // Zero numerator with a negative denominator.
    push_pair(OP_ADD, 0, 3, 0, -5);
    // Negative denominator kept as computed.
    push_pair(OP_DIV, 6, -4, 9, -2);
    push_pair(OP_MUL, -1, -1, -1, -1);
    // Field extremes for every operation.
    push_pair(OP_ADD, omin, omin, omin, omin);
    push_pair(OP_SUB, omin, omin, omin, omin);
    push_pair(OP_MUL, omin, omin, omin, omin);
    push_pair(OP_DIV, omin, omin, omin, omin);
    push_pair(OP_ADD, omax, omax, omax, omax);
    push_pair(OP_SUB, omax, omax, omax, omax);
    push_pair(OP_MUL, omax, omax, omax, omax);
    push_pair(OP_DIV, omax, omax, omax, omax);
    push_pair(OP_MUL, omin, 1, omin, 1);
    push_pair(OP_ADD, omin, omax, omax, omin);
    push_pair(OP_SUB, omax, 1, omin, 1);
    push_pair(OP_DIV, omax, omin, omin, omax);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      // Two halves per phase, with a full drain between them.
      for (int half = 0; half < 2; half++) begin
        for (int k = 0; k < 80; k++) begin
          push_pair(op_e'($urandom_range(3)), pick_operand(), pick_operand(),
                    pick_operand(), pick_operand());
        end
        drain();
      end
    end

    repeat (SETTLE_TICKS) @(negedge clk_i);

    $display("Sent %0d fraction pairs across four idling patterns; %0d results checked.",
             pairs_sent, results_seen);
    $display("Zero-gcd flag seen %0d times; %0d mismatches.", zero_gcd_seen, fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

### rational_arithmetic_unit.f
hw/rtl/rau_pkg.sv
hw/rtl/rau_divider.sv
hw/rtl/rau_datapath.sv
hw/rtl/rau_sequencer.sv
hw/rtl/rational_arithmetic_unit.sv
tb/tb.sv
